@@ design/sfr_pkg.sv @@
// Shared types, constants and the CRC step for the servo bus frame receiver.
package sfr_pkg;

    typedef enum logic [1:0] {
        PS_START,
        PS_TYPE,
        PS_LEN,
        PS_BODY
    } sfr_parse_state_t;

    typedef enum logic [2:0] {
        EM_IDLE,
        EM_RD_LO,
        EM_RD_HI,
        EM_CAP,
        EM_OUT
    } sfr_emit_state_t;

    localparam logic [1:0] KIND_CHAN = 2'd0;
    localparam logic [1:0] KIND_TELEM = 2'd1;
    localparam logic [1:0] KIND_TEXT = 2'd2;

    localparam logic [7:0] START_A = 8'h3D;
    localparam logic [7:0] START_B = 8'h3E;
    localparam logic [7:0] TYPE_A = 8'h01;
    localparam logic [7:0] TYPE_B = 8'h03;
    localparam logic [7:0] ID_CHAN = 8'h31;
    localparam logic [7:0] ID_TELEM = 8'h3A;
    localparam logic [7:0] ID_TEXT = 8'h3B;
    localparam logic [7:0] MIN_LEN = 8'd8;
    localparam logic [7:0] CHAN_OFS = 8'd6;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] id;
        logic [5:0] count;
        logic [3:0] keys;
    } sfr_job_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] d;
        d = b ^ crc[7:0];
        d = d ^ {d[3:0], 4'h0};
        return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
    endfunction

endpackage

@@ design/sfr_frame_mem.sv @@
// Frame byte store: one write port, one registered read port.
module sfr_frame_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ design/sfr_parser.sv @@
// Header search, frame store writes, running CRC and frame-end decode.
module sfr_parser #(
    parameter int BUFFER_BYTES = 64,
    parameter int MAX_CHANNELS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [7:0]                      rx_byte,
    input  logic                            parity_error,
    output logic                            wr_en,
    output logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
    output logic [7:0]                      wr_data,
    output sfr_pkg::sfr_job_t               job
);
    import sfr_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    sfr_parse_state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    len_reg, len_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       start_reg, type_reg, id_reg, ident_reg, b5_reg, b6_reg, tlo_reg;

    logic          take;
    logic [CW:0]   cnt_inc;
    logic [CW:0]   cnt_inc2;
    logic [CW:0]   len_w;
    logic          crc_ok;
    logic          is_chan;
    logic          is_telem;
    logic          is_text;
    logic [8:0]    half5;
    logic [8:0]    room;
    logic [8:0]    n_a;
    logic [8:0]    n_b;

    assign take = accept && !parity_error;
    assign cnt_inc = {1'b0, cnt_reg} + {{CW{1'b0}}, 1'b1};
    assign cnt_inc2 = cnt_inc + {{CW{1'b0}}, 1'b1};
    assign len_w = {1'b0, len_reg};
    assign wr_data = rx_byte;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        len_next = len_reg;
        crc_next = crc_reg;
        wr_en = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        if (take)
        begin
            case (state_reg)
                PS_START:
                begin
                    wr_addr = '0;
                    if (rx_byte == START_A || rx_byte == START_B)
                    begin
                        wr_en = 1'b1;
                        crc_next = crc_step(16'h0000, rx_byte);
                        state_next = PS_TYPE;
                    end
                end
                PS_TYPE:
                begin
                    wr_addr = AW'(1);
                    if (rx_byte == TYPE_A || rx_byte == TYPE_B)
                    begin
                        wr_en = 1'b1;
                        crc_next = crc_step(crc_reg, rx_byte);
                        state_next = PS_LEN;
                    end
                    else
                    begin
                        state_next = PS_START;
                    end
                end
                PS_LEN:
                begin
                    wr_addr = AW'(2);
                    if (rx_byte < MIN_LEN || {1'b0, rx_byte} > 9'(BUFFER_BYTES))
                    begin
                        state_next = PS_START;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        crc_next = crc_step(crc_reg, rx_byte);
                        len_next = CW'(rx_byte);
                        cnt_next = CW'(3);
                        state_next = PS_BODY;
                    end
                end
                PS_BODY:
                begin
                    if (cnt_reg >= len_reg)
                    begin
                        state_next = PS_START;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        if (cnt_inc2 < len_w)
                        begin
                            crc_next = crc_step(crc_reg, rx_byte);
                        end
                        cnt_next = cnt_inc[CW-1:0];
                        if (cnt_inc == len_w)
                        begin
                            state_next = PS_START;
                        end
                    end
                end
                default:
                begin
                    state_next = PS_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_START;
            cnt_reg <= '0;
            len_reg <= '0;
            crc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            len_reg <= len_next;
            crc_reg <= crc_next;
        end
    end

    // header and trailer shadows
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (state_reg == PS_START)
            begin
                start_reg <= rx_byte;
            end
            if (state_reg == PS_TYPE)
            begin
                type_reg <= rx_byte;
            end
            if (state_reg == PS_BODY)
            begin
                if (cnt_reg == CW'(3))
                begin
                    id_reg <= rx_byte;
                end
                if (cnt_reg == CW'(4))
                begin
                    ident_reg <= rx_byte;
                end
                if (cnt_reg == CW'(5))
                begin
                    b5_reg <= rx_byte;
                end
                if (cnt_reg == CW'(6))
                begin
                    b6_reg <= rx_byte;
                end
                if (cnt_inc2 == len_w)
                begin
                    tlo_reg <= rx_byte;
                end
            end
        end
    end

    assign crc_ok = (crc_reg == {rx_byte, tlo_reg});
    assign is_chan = (start_reg == START_B) && (ident_reg == ID_CHAN);
    assign is_telem = (type_reg == TYPE_A) && (ident_reg == ID_TELEM);
    assign is_text = (type_reg == TYPE_A) && (ident_reg == ID_TEXT);
    assign half5 = {2'b00, b5_reg[7:1]};
    assign room = 9'((len_w - (CW+1)'(8)) >> 1);
    assign n_a = (half5 > 9'(MAX_CHANNELS)) ? 9'(MAX_CHANNELS) : half5;
    assign n_b = (n_a > room) ? room : n_a;

    always_comb
    begin
        job = '0;
        job.id = id_reg;
        job.keys = ~b6_reg[7:4];
        if (take && state_reg == PS_BODY && cnt_reg < len_reg && cnt_inc == len_w && crc_ok)
        begin
            if (is_chan)
            begin
                job.kind = KIND_CHAN;
                job.count = n_b[5:0];
                job.valid = (n_b != 9'd0);
            end
            else if (is_telem)
            begin
                job.kind = KIND_TELEM;
                job.valid = 1'b1;
            end
            else if (is_text)
            begin
                job.kind = KIND_TEXT;
                job.valid = 1'b1;
            end
        end
    end
endmodule

@@ design/sfr_emit.sv @@
// Result sequencer: reads channel values back from the frame store and presents results.
module sfr_emit #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sfr_pkg::sfr_job_t               job,
    output logic                            busy,
    output logic                            rd_en,
    output logic [$clog2(BUFFER_BYTES)-1:0] rd_addr,
    input  logic [7:0]                      rd_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      kind,
    output logic [7:0]                      packet_id,
    output logic [4:0]                      channel_index,
    output logic [15:0]                     channel_value,
    output logic [3:0]                      key_bits,
    output logic                            last
);
    import sfr_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    sfr_emit_state_t state_reg, state_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [5:0]      idx_reg, idx_next;
    logic [5:0]      n_reg;
    logic [7:0]      lo_reg;
    logic [5:0]      idx_inc;
    logic            load_job;
    logic            load_chan;

    assign idx_inc = idx_reg + 6'd1;
    assign busy = (state_reg != EM_IDLE);
    assign out_valid = (state_reg == EM_OUT);
    assign rd_addr = addr_reg;

    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        idx_next = idx_reg;
        rd_en = 1'b0;
        load_job = 1'b0;
        load_chan = 1'b0;
        case (state_reg)
            EM_IDLE:
            begin
                if (job.valid)
                begin
                    load_job = 1'b1;
                    addr_next = AW'(CHAN_OFS);
                    idx_next = '0;
                    state_next = (job.kind == KIND_CHAN) ? EM_RD_LO : EM_OUT;
                end
            end
            EM_RD_LO:
            begin
                rd_en = 1'b1;
                addr_next = addr_reg + AW'(1);
                state_next = EM_RD_HI;
            end
            EM_RD_HI:
            begin
                rd_en = 1'b1;
                addr_next = addr_reg + AW'(1);
                state_next = EM_CAP;
            end
            EM_CAP:
            begin
                load_chan = 1'b1;
                state_next = EM_OUT;
            end
            EM_OUT:
            begin
                if (out_ready)
                begin
                    if (last)
                    begin
                        state_next = EM_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        state_next = EM_RD_LO;
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            addr_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == EM_RD_HI)
        begin
            lo_reg <= rd_data;
        end
        if (load_job)
        begin
            n_reg <= job.count;
            kind <= job.kind;
            packet_id <= job.id;
            channel_index <= '0;
            channel_value <= '0;
            key_bits <= (job.kind == KIND_TEXT) ? job.keys : 4'h0;
            last <= 1'b1;
        end
        if (load_chan)
        begin
            channel_index <= idx_reg[4:0];
            channel_value <= {rd_data, lo_reg};
            last <= (idx_inc == n_reg);
        end
    end
endmodule

@@ design/servo_bus_frame_receiver.sv @@
// Servo bus frame receiver top level: byte input, frame store, parser and result sequencer.
//
// Input channel (in_valid/in_ready, rx_byte, parity_error): one received serial byte per
// request. Bytes flagged with parity_error are taken and dropped. For each accepted byte
// the parser checks the header, writes the byte into the frame store and folds it into
// the running CRC, except the two trailing CRC bytes, which are not folded in.
// Output channel (out_valid/out_ready, kind, packet_id, channel_index, channel_value,
// key_bits, last): one request per result; last marks the final result of a frame.
// A telemetry or text box result is valid on the cycle after the frame's final byte.
// A channel frame walks the frame store: for each value the sequencer reads the low and
// high bytes through the registered read port (EM_RD_LO, EM_RD_HI), captures the value
// (EM_CAP) and presents it (EM_OUT); the next value is read only once out_ready is high.
// in_ready is low from the cycle after the frame's final byte until the cycle after its
// last result is taken.
// A stalled receiver holds the current result and the input stays blocked.
// Reset returns the parser to header search; the frame store is not cleared.
module servo_bus_frame_receiver #(
    parameter int BUFFER_BYTES = 64,
    parameter int MAX_CHANNELS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        parity_error,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  packet_id,
    output logic [4:0]  channel_index,
    output logic [15:0] channel_value,
    output logic [3:0]  key_bits,
    output logic        last
);
    import sfr_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic          accept;
    logic          busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    sfr_job_t      job;

    assign in_ready = !busy;
    assign accept = in_valid && in_ready;

    sfr_frame_mem #(
        .DEPTH(BUFFER_BYTES)
    ) u_mem (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    sfr_parser #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .rx_byte(rx_byte),
        .parity_error(parity_error),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .job(job)
    );

    sfr_emit #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_emit (
        .clk(clk),
        .rst_n(rst_n),
        .job(job),
        .busy(busy),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .packet_id(packet_id),
        .channel_index(channel_index),
        .channel_value(channel_value),
        .key_bits(key_bits),
        .last(last)
    );
endmodule
